// ===== rtl/tpm_pkg.sv =====
// Package for the polygon vertex to toolpath move block.
// Holds widths, types, register codes and reset values shared by every file.
package tpm_pkg;

  localparam int COORD_BITS = 24;
  localparam int DIFF_W     = COORD_BITS + 1;
  localparam int ROOT_W     = COORD_BITS + 1;
  localparam int RAD_W      = 2 * ROOT_W;
  localparam int REM_W      = ROOT_W + 2;
  localparam int CNT_W      = $clog2(ROOT_W + 1);

  localparam int Z_W        = 24;
  localparam int SPEED_W    = 16;
  localparam int DIM_W      = 12;
  localparam int FLOW_W     = 16;
  localparam int VOL_W      = 48;
  localparam int FRAC_W     = 8;

  localparam int LWLT_W     = 2 * DIM_W;
  localparam int Q_W        = LWLT_W + FLOW_W;
  localparam int Q_SPLIT    = Q_W / 2;
  localparam int QHI_W      = Q_W - Q_SPLIT;
  localparam int MUL_W      = (ROOT_W > LWLT_W) ? ROOT_W : LWLT_W;
  localparam int PROD_W     = 2 * MUL_W;
  localparam int TOT_W      = PROD_W + Q_SPLIT + 1;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic [Z_W-1:0]               zpos_t;
  typedef logic [SPEED_W-1:0]           speed_t;
  typedef logic [DIM_W-1:0]             dim_t;
  typedef logic [FLOW_W-1:0]            flow_t;
  typedef logic [VOL_W-1:0]             vol_t;
  typedef logic [MUL_W-1:0]             mul_op_t;
  typedef logic [PROD_W-1:0]            prod_t;
  typedef logic [RAD_W-1:0]             rad_t;
  typedef logic [ROOT_W-1:0]            root_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TRAVEL_RATE     = 3'd0,
    REG_PRINT_RATE      = 3'd1,
    REG_BEAD_WIDTH      = 3'd2,
    REG_LAYER_THICKNESS = 3'd3,
    REG_FLOW_MULTIPLIER = 3'd4,
    REG_EXTRUDE_ENABLE  = 3'd5
  } cfg_reg_t;

  localparam logic MOVE_TRAVEL = 1'b0;
  localparam logic MOVE_PRINT  = 1'b1;

  localparam speed_t RST_TRAVEL_RATE     = 16'd6000;
  localparam speed_t RST_PRINT_RATE      = 16'd1800;
  localparam dim_t   RST_BEAD_WIDTH      = 12'd400;
  localparam dim_t   RST_LAYER_THICKNESS = 12'd200;
  localparam flow_t  RST_FLOW_MULTIPLIER = 16'd256;
  localparam logic   RST_EXTRUDE_ENABLE  = 1'b1;

  localparam vol_t VOL_MAX = {VOL_W{1'b1}};

  typedef struct packed {
    speed_t travel_rate;
    speed_t print_rate;
    dim_t   bead_width;
    dim_t   layer_thickness;
    flow_t  flow_multiplier;
    logic   extrude_enable;
  } cfg_t;

endpackage

// ===== rtl/tpm_if.sv =====
// Channel interfaces of the toolpath move block: vertex in, move out, register writes.
// Depends on tpm_pkg.
interface tpm_vertex_if;
  import tpm_pkg::*;
  logic   valid;
  logic   ready;
  coord_t vertex_x;
  coord_t vertex_y;
  zpos_t  layer_z;
  logic   first_vertex;
  logic   last_vertex;
  modport source (output valid, vertex_x, vertex_y, layer_z, first_vertex, last_vertex,
                  input ready);
  modport sink   (input valid, vertex_x, vertex_y, layer_z, first_vertex, last_vertex,
                  output ready);
endinterface

interface tpm_move_if;
  import tpm_pkg::*;
  logic   valid;
  logic   ready;
  logic   move_kind;
  coord_t target_x;
  coord_t target_y;
  zpos_t  target_z;
  speed_t move_speed;
  vol_t   extrude_volume;
  logic   run_end;
  modport source (output valid, move_kind, target_x, target_y, target_z, move_speed,
                  extrude_volume, run_end, input ready);
  modport sink   (input valid, move_kind, target_x, target_y, target_z, move_speed,
                  extrude_volume, run_end, output ready);
endinterface

interface tpm_cfg_if;
  import tpm_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/tpm_cfg_regs.sv =====
// Configuration register file of the toolpath move block.
// Depends on tpm_pkg.
module tpm_cfg_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           wr_valid,
  input  logic [tpm_pkg::CFG_IDX_W-1:0]  wr_index,
  input  logic [tpm_pkg::CFG_DATA_W-1:0] wr_data,
  output tpm_pkg::cfg_t                  regs
);
  import tpm_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.travel_rate     <= RST_TRAVEL_RATE;
      regs.print_rate      <= RST_PRINT_RATE;
      regs.bead_width      <= RST_BEAD_WIDTH;
      regs.layer_thickness <= RST_LAYER_THICKNESS;
      regs.flow_multiplier <= RST_FLOW_MULTIPLIER;
      regs.extrude_enable  <= RST_EXTRUDE_ENABLE;
    end else if (wr_valid) begin
      case (cfg_reg_t'(wr_index))
        REG_TRAVEL_RATE:     regs.travel_rate     <= wr_data[SPEED_W-1:0];
        REG_PRINT_RATE:      regs.print_rate      <= wr_data[SPEED_W-1:0];
        REG_BEAD_WIDTH:      regs.bead_width      <= wr_data[DIM_W-1:0];
        REG_LAYER_THICKNESS: regs.layer_thickness <= wr_data[DIM_W-1:0];
        REG_FLOW_MULTIPLIER: regs.flow_multiplier <= wr_data[FLOW_W-1:0];
        REG_EXTRUDE_ENABLE:  regs.extrude_enable  <= wr_data[0];
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/tpm_mul.sv =====
// Shared multiplier of the toolpath move block, product registered.
// Depends on tpm_pkg.
module tpm_mul (
  input  logic              clk,
  input  tpm_pkg::mul_op_t  a,
  input  tpm_pkg::mul_op_t  b,
  output tpm_pkg::prod_t    p
);
  import tpm_pkg::*;

  always_ff @(posedge clk) begin
    p <= PROD_W'(a) * PROD_W'(b);
  end

endmodule

// ===== rtl/tpm_isqrt.sv =====
// Bit-serial integer square root, one root bit per cycle.
// Depends on tpm_pkg.
module tpm_isqrt (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  tpm_pkg::rad_t   radicand,
  output tpm_pkg::root_t  root,
  output logic            busy
);
  import tpm_pkg::*;

  rad_t              rad_sh;
  logic [REM_W-1:0]  rem;
  logic [CNT_W-1:0]  cnt;
  logic [REM_W-1:0]  rem_sh;
  logic [REM_W-1:0]  trial;
  logic              fits;

  always_comb begin
    rem_sh = {rem[ROOT_W-1:0], rad_sh[RAD_W-1 -: 2]};
    trial  = {root, 2'b01};
    fits   = (rem_sh >= trial);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      rad_sh <= radicand;
      rem    <= '0;
      root   <= '0;
      cnt    <= CNT_W'(ROOT_W);
      busy   <= 1'b1;
    end else if (busy) begin
      rad_sh <= rad_sh << 2;
      rem    <= fits ? (rem_sh - trial) : rem_sh;
      root   <= {root[ROOT_W-2:0], fits};
      cnt    <= cnt - CNT_W'(1);
      if (cnt == CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/polygon_vertex_to_toolpath_moves.sv =====
// Top level of the polygon vertex to toolpath move block.
// Depends on tpm_pkg, tpm_if, tpm_cfg_regs, tpm_mul and tpm_isqrt.
//
// Usage:
//   vertex : one polygon vertex per transaction, with first/last marks and layer z.
//   move   : one or two moves per vertex; run_end marks the last move of a vertex.
//   cfg    : register writes (index, data), always ready; write only while idle.
// A first vertex gives a travel move. Any other vertex gives a print move from the
// previous vertex; a last vertex adds a closing print move back to the first one.
// Travel moves and moves with extrusion off take no arithmetic and go from S_SETUP
// straight to S_EMIT and the output register. An extruding print move goes through
// the differences, two squarings, one root bit per cycle in the square root unit,
// then four passes through the single shared multiplier and a saturating sum.
// A closing move runs the same sequence again. vertex.ready is high only while the
// sequencer is idle, so a vertex holds the input until its last move enters the output register.
// A move waits in the output register while the receiver stalls; the sequencer
// holds a finished move until that register is free.
// Reset restores the register defaults and clears the stored first and previous
// vertices to zero.
module polygon_vertex_to_toolpath_moves (
  input logic      clk,
  input logic      rst,
  tpm_vertex_if.sink vertex,
  tpm_move_if.source move,
  tpm_cfg_if.sink    cfg
);
  import tpm_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SETUP,
    S_DIFF,
    S_SQX,
    S_SQY,
    S_ADD,
    S_ROOT,
    S_QLT,
    S_QFLOW,
    S_QLO,
    S_QHI,
    S_SUM,
    S_EMIT
  } state_t;

  state_t state;
  cfg_t   regs;

  coord_t start_x, start_y, prior_x, prior_y;
  coord_t jfx, jfy, jtx, jty;
  zpos_t  jz;
  logic   jkind, jend, pend2;

  logic [DIFF_W-1:0] ax, ay;
  rad_t              rad;
  prod_t             acc;
  logic [QHI_W-1:0]  qhi;
  vol_t              vol;

  logic   out_valid;
  logic   out_kind;
  coord_t out_x, out_y;
  zpos_t  out_z;
  speed_t out_speed;
  vol_t   out_vol;
  logic   out_end;

  mul_op_t mul_a, mul_b;
  prod_t   prod;
  logic    sq_start, sq_busy;
  root_t   root;
  rad_t    radicand;

  logic              accept, out_load;
  logic [DIFF_W-1:0] dx, dy;
  logic [TOT_W-1:0]  total;
  vol_t              vol_sat;

  tpm_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (cfg.valid),
    .wr_index (cfg.index),
    .wr_data  (cfg.data),
    .regs     (regs)
  );

  tpm_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  tpm_isqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sq_start),
    .radicand (radicand),
    .root     (root),
    .busy     (sq_busy)
  );

  assign cfg.ready    = 1'b1;
  assign vertex.ready = (state == S_IDLE);
  assign accept       = vertex.valid && vertex.ready;
  assign out_load     = (state == S_EMIT) && (!out_valid || move.ready);

  assign move.valid          = out_valid;
  assign move.move_kind      = out_kind;
  assign move.target_x       = out_x;
  assign move.target_y       = out_y;
  assign move.target_z       = out_z;
  assign move.move_speed     = out_speed;
  assign move.extrude_volume = out_vol;
  assign move.run_end        = out_end;

  assign sq_start = (state == S_ADD);
  assign radicand = rad + prod[RAD_W-1:0];

  always_comb begin
    dx = {jtx[COORD_BITS-1], jtx} - {jfx[COORD_BITS-1], jfx};
    dy = {jty[COORD_BITS-1], jty} - {jfy[COORD_BITS-1], jfy};
    total = TOT_W'(acc) + (TOT_W'(prod) << Q_SPLIT);
    if (|total[TOT_W-1:FRAC_W+VOL_W]) begin
      vol_sat = VOL_MAX;
    end else begin
      vol_sat = total[FRAC_W+VOL_W-1:FRAC_W];
    end
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_SQX: begin
        mul_a = MUL_W'(ax);
        mul_b = MUL_W'(ax);
      end
      S_SQY: begin
        mul_a = MUL_W'(ay);
        mul_b = MUL_W'(ay);
      end
      S_QLT: begin
        mul_a = MUL_W'(regs.bead_width);
        mul_b = MUL_W'(regs.layer_thickness);
      end
      S_QFLOW: begin
        mul_a = MUL_W'(prod[LWLT_W-1:0]);
        mul_b = MUL_W'(regs.flow_multiplier);
      end
      S_QLO: begin
        mul_a = MUL_W'(prod[Q_SPLIT-1:0]);
        mul_b = MUL_W'(root);
      end
      S_QHI: begin
        mul_a = MUL_W'(qhi);
        mul_b = MUL_W'(root);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      pend2     <= 1'b0;
      start_x   <= '0;
      start_y   <= '0;
      prior_x   <= '0;
      prior_y   <= '0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (move.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            jfx     <= prior_x;
            jfy     <= prior_y;
            jtx     <= vertex.vertex_x;
            jty     <= vertex.vertex_y;
            jz      <= vertex.layer_z;
            jkind   <= vertex.first_vertex ? MOVE_TRAVEL : MOVE_PRINT;
            jend    <= !vertex.last_vertex;
            pend2   <= vertex.last_vertex;
            prior_x <= vertex.vertex_x;
            prior_y <= vertex.vertex_y;
            if (vertex.first_vertex) begin
              start_x <= vertex.vertex_x;
              start_y <= vertex.vertex_y;
            end
            state <= S_SETUP;
          end
        end
        S_SETUP: begin
          if (jkind == MOVE_TRAVEL || !regs.extrude_enable) begin
            vol   <= '0;
            state <= S_EMIT;
          end else begin
            state <= S_DIFF;
          end
        end
        S_DIFF: begin
          ax    <= dx[DIFF_W-1] ? (~dx + DIFF_W'(1)) : dx;
          ay    <= dy[DIFF_W-1] ? (~dy + DIFF_W'(1)) : dy;
          state <= S_SQX;
        end
        S_SQX: begin
          state <= S_SQY;
        end
        S_SQY: begin
          rad   <= prod[RAD_W-1:0];
          state <= S_ADD;
        end
        S_ADD: begin
          state <= S_ROOT;
        end
        S_ROOT: begin
          if (!sq_busy) begin
            state <= S_QLT;
          end
        end
        S_QLT: begin
          state <= S_QFLOW;
        end
        S_QFLOW: begin
          state <= S_QLO;
        end
        S_QLO: begin
          qhi   <= prod[Q_W-1:Q_SPLIT];
          state <= S_QHI;
        end
        S_QHI: begin
          acc   <= prod;
          state <= S_SUM;
        end
        S_SUM: begin
          vol   <= vol_sat;
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (out_load) begin
            out_kind  <= jkind;
            out_x     <= jtx;
            out_y     <= jty;
            out_z     <= jz;
            out_speed <= (jkind == MOVE_PRINT && regs.extrude_enable) ?
                         regs.print_rate : regs.travel_rate;
            out_vol   <= vol;
            out_end   <= jend;
            if (pend2) begin
              pend2 <= 1'b0;
              jfx   <= jtx;
              jfy   <= jty;
              jtx   <= start_x;
              jty   <= start_y;
              jkind <= MOVE_PRINT;
              jend  <= 1'b1;
              state <= S_SETUP;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/tpm_checker.sv =====
// Port-level checks for the toolpath move block, bound to the top level.
// Depends on tpm_pkg.
module tpm_checker (
  input logic            clk,
  input logic            rst,
  input logic            in_valid,
  input logic            in_ready,
  input logic            out_valid,
  input logic            out_ready,
  input logic            out_kind,
  input tpm_pkg::vol_t   out_vol,
  input logic            out_end
);
  import tpm_pkg::*;

  property p_stall_hold;
    @(posedge clk) disable iff (rst)
      out_valid && !out_ready |=> out_valid && $stable(out_vol) && $stable(out_end);
  endproperty
  a_stall_hold: assert property (p_stall_hold) else $error("move changed while stalled");

  property p_travel_dry;
    @(posedge clk) disable iff (rst)
      out_valid && (out_kind == MOVE_TRAVEL) |-> (out_vol == '0);
  endproperty
  a_travel_dry: assert property (p_travel_dry) else $error("travel move extrudes");

  property p_busy_after_accept;
    @(posedge clk) disable iff (rst)
      in_valid && in_ready |=> !in_ready;
  endproperty
  a_busy_after_accept: assert property (p_busy_after_accept)
    else $error("vertex taken while busy");

  property p_closing_pending;
    @(posedge clk) disable iff (rst)
      out_valid && !out_end |-> !in_ready;
  endproperty
  a_closing_pending: assert property (p_closing_pending)
    else $error("idle with closing move outstanding");

  property p_closing_is_print;
    @(posedge clk) disable iff (rst)
      out_valid && out_ready && !out_end |=> !(out_valid && out_kind == MOVE_TRAVEL);
  endproperty
  a_closing_is_print: assert property (p_closing_is_print)
    else $error("closing move is a travel move");

endmodule

bind polygon_vertex_to_toolpath_moves tpm_checker u_tpm_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (vertex.valid),
  .in_ready  (vertex.ready),
  .out_valid (move.valid),
  .out_ready (move.ready),
  .out_kind  (move.move_kind),
  .out_vol   (move.extrude_volume),
  .out_end   (move.run_end)
);
